// File: rtl/core/mtt_pkg.sv
// Shared types, constants and functions of the mate transposition table.
package mtt_pkg;

	localparam int TableSize  = 4096;
	localparam int SlotW      = $clog2(TableSize);
	localparam int ProbeLimit = 8;
	localparam int ChainLimit = 16;
	localparam int ProbeW     = $clog2(ProbeLimit + 1);
	localparam int ChainW     = $clog2(ChainLimit + 1);
	localparam logic [SlotW-1:0] ProbeStride = SlotW'(TableSize / 11);

	localparam int KeyW  = 64;
	localparam int HandW = 40;
	localparam int MateW = 8;
	localparam int MoveW = 32;

	typedef enum logic [1:0] {
		KIND_INSERT = 2'd0,
		KIND_EXACT  = 2'd1,
		KIND_DOM    = 2'd2,
		KIND_CLEAR  = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_INSERTED = 3'd0,
		ST_UPDATED  = 3'd1,
		ST_DROPPED  = 3'd2,
		ST_HIT      = 3'd3,
		ST_MISS     = 3'd4,
		ST_CLEARED  = 3'd5
	} status_t;

	typedef struct packed {
		logic [HandW-1:0] hand;
		logic [MateW-1:0] mate;
		logic [MoveW-1:0] move;
		logic [SlotW-1:0] link;
	} entry_t;

	typedef struct packed {
		logic             key_we;
		logic [KeyW-1:0]  key_wdata;
		logic             ent_we;
		entry_t           ent_wdata;
		logic [SlotW-1:0] waddr;
		logic             rd;
		logic [SlotW-1:0] raddr;
	} mem_req_t;

	typedef struct packed {
		logic [KeyW-1:0] key;
		logic            key_zero;
		entry_t          ent;
	} mem_rsp_t;

	function automatic logic [3:0] thermo4(input logic [2:0] c);
		logic [2:0] s;
		s = (c > 3'd4) ? 3'd4 : c;
		thermo4 = 4'((5'd1 << s) - 5'd1);
	endfunction

	function automatic logic [1:0] thermo2(input logic [1:0] c);
		logic [1:0] s;
		s = (c > 2'd2) ? 2'd2 : c;
		thermo2 = 2'((3'd1 << s) - 3'd1);
	endfunction

	function automatic logic [HandW-1:0] pack_hand(input logic [4:0] p, input logic [2:0] l,
			input logic [2:0] n, input logic [2:0] s, input logic [2:0] g,
			input logic [1:0] b, input logic [1:0] r);
		logic [18:0] pw;
		pw = (p >= 5'd18) ? 19'h7FFFF : 19'((20'd1 << p) - 20'd1);
		pack_hand = {thermo2(r), thermo2(b), thermo4(g), thermo4(s), thermo4(n), thermo4(l),
			1'b0, pw};
	endfunction

endpackage

// File: rtl/core/mate_transposition_table.sv
// Top level of the mate transposition table.
// One operation is taken at a time and answers with one transaction. After reset, and again
// after each clear, the block zeroes its 4096 keys one per cycle and holds s_tready low
// while it does so. A clear or an operation with a zero board hash raises m_tvalid in the
// cycle after acceptance. A find or insert first probes the table, one memory read per
// cycle, and then walks the chain of the matching key entry by entry; an insert that chains
// a new hand then probes a second sequence and writes the link. The longest operation takes
// 8 probes, 17 chain entries and 8 second probes. A new transaction is accepted from the
// clock edge after the result is taken, unless a key clearing pass is still running.
module mate_transposition_table import mtt_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	// kind
	input  logic [1:0]    s_tuser,
	// board_hash, hand_hash, pawn, lance, knight, silver, gold, bishop, rook,
	// mate_value, move_word; 189 bits in 192
	input  logic [191:0]  s_tdata,
	output logic          m_tvalid,
	input  logic          m_tready,
	// status
	output logic [2:0]    m_tuser,
	// slot_index, found_mate, found_move, found_hand; 92 bits in 96
	output logic [95:0]   m_tdata
);

	mem_req_t req;
	mem_rsp_t rsp;
	logic     clear;
	logic     clr_busy;
	logic [SlotW-1:0] slot;
	logic [MateW-1:0] fm;
	logic [MoveW-1:0] fmv;
	logic [HandW-1:0] fh;

	mtt_store u_store (.clk, .arst_n, .clear, .req, .rsp, .clr_busy);

	mtt_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(s_tvalid), .in_ready(s_tready),
		.in_kind(s_tuser), .in_key(s_tdata[63:0]), .in_hhash(s_tdata[127:64]),
		.in_hand(pack_hand(s_tdata[132:128], s_tdata[135:133], s_tdata[138:136],
			s_tdata[141:139], s_tdata[144:142], s_tdata[146:145], s_tdata[148:147])),
		.in_mate(s_tdata[156:149]), .in_move(s_tdata[188:157]),
		.req, .clear, .rsp, .clr_busy,
		.out_valid(m_tvalid), .out_ready(m_tready),
		.out_status(m_tuser), .out_slot(slot), .out_mate(fm), .out_move(fmv), .out_hand(fh)
	);

	assign m_tdata = {4'b0, fh, fmv, fm, slot};

endmodule

// File: rtl/core/mtt_store.sv
// Slot memories with a registered read and a key clearing pass after reset and on clear.
module mtt_store import mtt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     clear,
	input  mem_req_t req,
	output mem_rsp_t rsp,
	output logic     clr_busy
);

	logic [KeyW-1:0]  key_mem [TableSize];
	entry_t           ent_mem [TableSize];
	logic             sweep_q;
	logic [SlotW-1:0] sweep_addr_q;
	logic [KeyW-1:0]  rd_key_s1;
	entry_t           rd_ent_s1;

	// The keys are zeroed one slot per cycle after reset and after each clear.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q      <= 1'b1;
			sweep_addr_q <= '0;
		end else if (sweep_q) begin
			sweep_addr_q <= sweep_addr_q + SlotW'(1);
			if (sweep_addr_q == SlotW'(TableSize - 1)) begin
				sweep_q <= 1'b0;
			end
		end else if (clear) begin
			sweep_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (sweep_q) begin
			key_mem[sweep_addr_q] <= '0;
		end else if (req.key_we) begin
			key_mem[req.waddr] <= req.key_wdata;
		end
		if (req.ent_we) begin
			ent_mem[req.waddr] <= req.ent_wdata;
		end
		if (req.rd) begin
			rd_key_s1 <= key_mem[req.raddr];
			rd_ent_s1 <= ent_mem[req.raddr];
		end
	end

	assign clr_busy = sweep_q;

	always_comb begin
		rsp.ent      = rd_ent_s1;
		rsp.key_zero = (rd_key_s1 == '0);
		rsp.key      = rd_key_s1;
	end

endmodule

// File: rtl/core/mtt_ctrl.sv
// Sequencer for probe, chain walk and write back of one operation.
module mtt_ctrl import mtt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        in_kind,
	input  logic [KeyW-1:0]   in_key,
	input  logic [KeyW-1:0]   in_hhash,
	input  logic [HandW-1:0]  in_hand,
	input  logic [MateW-1:0]  in_mate,
	input  logic [MoveW-1:0]  in_move,
	output mem_req_t          req,
	output logic              clear,
	input  mem_rsp_t          rsp,
	input  logic              clr_busy,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [2:0]        out_status,
	output logic [SlotW-1:0]  out_slot,
	output logic [MateW-1:0]  out_mate,
	output logic [MoveW-1:0]  out_move,
	output logic [HandW-1:0]  out_hand
);

	typedef enum logic [2:0] {
		S_IDLE, S_PROBE, S_CHAIN, S_PROBE2, S_LINK, S_DONE
	} state_t;

	state_t           state_q;
	kind_t            kind_q;
	logic [KeyW-1:0]  key_q, hh_q;
	logic [HandW-1:0] hand_q;
	logic [MateW-1:0] mate_q;
	logic [MoveW-1:0] move_q;
	logic [SlotW-1:0] addr_q, cur_q, tail_slot_q;
	logic [ProbeW-1:0] cnt_q;
	logic [ChainW-1:0] steps_q;
	logic             busy_q;
	// Held copy of the chain tail entry, rewritten with the new link after a chained insert.
	entry_t           tail_q;

	logic hand_eq, subset, is_mate;
	assign hand_eq = rsp.ent.hand == hand_q;
	assign subset  = (rsp.ent.hand & hand_q) == rsp.ent.hand;
	assign is_mate = rsp.ent.mate == MateW'(1);

	assign in_ready = (state_q == S_IDLE) && !out_valid && !clr_busy;
	assign clear    = in_valid && in_ready && kind_t'(in_kind) == KIND_CLEAR;

	entry_t new_ent;
	assign new_ent = '{hand: hand_q, mate: mate_q, move: move_q, link: '0};

	always_comb begin
		req = '0;
		req.raddr = addr_q;
		req.rd = 1'b1;
		if (state_q == S_PROBE && busy_q && rsp.key_zero && kind_q == KIND_INSERT) begin
			req.key_we = 1'b1; req.ent_we = 1'b1;
			req.waddr = cur_q; req.key_wdata = key_q; req.ent_wdata = new_ent;
		end else if (state_q == S_CHAIN && busy_q && kind_q == KIND_INSERT && hand_eq) begin
			req.ent_we = 1'b1; req.waddr = cur_q;
			req.ent_wdata = '{hand: rsp.ent.hand, mate: mate_q, move: move_q,
				link: rsp.ent.link};
		end else if (state_q == S_PROBE2 && busy_q && rsp.key_zero) begin
			req.key_we = 1'b1; req.ent_we = 1'b1;
			req.waddr = cur_q; req.key_wdata = key_q; req.ent_wdata = new_ent;
		end else if (state_q == S_LINK) begin
			req.ent_we = 1'b1; req.waddr = tail_slot_q; req.ent_wdata = tail_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; out_valid <= 1'b0; busy_q <= 1'b0;
			kind_q <= KIND_INSERT; cnt_q <= '0; steps_q <= '0;
			addr_q <= '0; cur_q <= '0; tail_slot_q <= '0; tail_q <= '0;
			key_q <= '0; hh_q <= '0; hand_q <= '0; mate_q <= '0; move_q <= '0;
			out_status <= ST_INSERTED; out_slot <= '0; out_mate <= '0; out_move <= '0;
			out_hand <= '0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						kind_q <= kind_t'(in_kind);
						key_q <= in_key; hh_q <= in_hhash; hand_q <= in_hand;
						mate_q <= in_mate; move_q <= in_move;
						out_slot <= '0; out_mate <= '0; out_move <= '0; out_hand <= '0;
						cnt_q <= '0; steps_q <= '0; busy_q <= 1'b0;
						addr_q <= in_key[SlotW-1:0];
						if (kind_t'(in_kind) == KIND_CLEAR) begin
							out_status <= ST_CLEARED; out_valid <= 1'b1;
						end else if (in_key == '0) begin
							out_status <= (kind_t'(in_kind) == KIND_INSERT) ? ST_DROPPED : ST_MISS;
							out_valid <= 1'b1;
						end else begin
							state_q <= S_PROBE;
						end
					end
				end
				S_PROBE: begin
					if (!busy_q) begin
						busy_q <= 1'b1; cur_q <= addr_q; addr_q <= addr_q + ProbeStride;
					end else if (rsp.key_zero && kind_q == KIND_INSERT) begin
						out_status <= ST_INSERTED; out_slot <= cur_q; state_q <= S_DONE;
					end else if (rsp.key == key_q) begin
						busy_q <= 1'b0; addr_q <= cur_q; state_q <= S_CHAIN;
					end else if (cnt_q == ProbeW'(ProbeLimit - 1)) begin
						out_status <= (kind_q == KIND_INSERT) ? ST_DROPPED : ST_MISS;
						state_q <= S_DONE;
					end else begin
						cnt_q <= cnt_q + ProbeW'(1); cur_q <= addr_q;
						addr_q <= addr_q + ProbeStride;
					end
				end
				S_CHAIN: begin
					if (!busy_q) begin
						busy_q <= 1'b1; cur_q <= addr_q;
					end else if (kind_q == KIND_INSERT) begin
						if (hand_eq) begin
							out_status <= ST_UPDATED; out_slot <= cur_q; state_q <= S_DONE;
						end else if (rsp.ent.link == '0) begin
							tail_q <= rsp.ent; tail_slot_q <= cur_q; busy_q <= 1'b0;
							cnt_q <= '0; addr_q <= SlotW'(key_q ^ hh_q);
							state_q <= S_PROBE2;
						end else if (steps_q == ChainW'(ChainLimit)) begin
							out_status <= ST_DROPPED; state_q <= S_DONE;
						end else begin
							steps_q <= steps_q + ChainW'(1); busy_q <= 1'b0;
							addr_q <= rsp.ent.link;
						end
					end else if ((kind_q == KIND_DOM && hand_eq && !is_mate)) begin
						out_status <= ST_MISS; state_q <= S_DONE;
					end else if ((kind_q == KIND_DOM && subset && is_mate) ||
							(kind_q == KIND_EXACT && hand_eq)) begin
						out_status <= ST_HIT; out_slot <= cur_q; out_mate <= rsp.ent.mate;
						out_move <= rsp.ent.move; out_hand <= rsp.ent.hand; state_q <= S_DONE;
					end else if (rsp.ent.link == '0 || steps_q == ChainW'(ChainLimit)) begin
						out_status <= ST_MISS; state_q <= S_DONE;
					end else begin
						steps_q <= steps_q + ChainW'(1); busy_q <= 1'b0;
						addr_q <= rsp.ent.link;
					end
				end
				S_PROBE2: begin
					if (!busy_q) begin
						busy_q <= 1'b1; cur_q <= addr_q; addr_q <= addr_q + ProbeStride;
					end else if (rsp.key_zero) begin
						out_status <= ST_INSERTED; out_slot <= cur_q;
						tail_q.link <= cur_q; state_q <= S_LINK;
					end else if (cnt_q == ProbeW'(ProbeLimit - 1)) begin
						out_status <= ST_DROPPED; state_q <= S_DONE;
					end else begin
						cnt_q <= cnt_q + ProbeW'(1); cur_q <= addr_q;
						addr_q <= addr_q + ProbeStride;
					end
				end
				S_LINK: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					state_q <= S_IDLE; out_valid <= 1'b1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid &&
			$stable({out_status, out_slot, out_mate, out_move, out_hand}));
	a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy |-> !in_ready);
	a_key_with_entry: assert property (@(posedge clk) disable iff (!arst_n)
		req.key_we |-> req.ent_we);
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_status <= ST_CLEARED));

endmodule
